>>> design/ffba_pkg.sv
// Package for the first-fit block allocator: result codes, controller states,
// alignment constants and the command and status structs between the controller and datapath.
// No dependencies.
package ffba_pkg;

  // Requests are rounded up to a multiple of this many bytes.
  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned ALIGN_BITS  = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_ZERO       = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SPLIT  = 6'b010000,
    S_REPLY  = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;      // request transfer: latch fields and start the table scan
    logic    init_wr;   // write entry 0 with the reset heap size
    logic    cfg_wr;    // configuration transfer: reset the table
    logic    set_used;  // mark the chosen segment used
    logic    clr_used;  // mark the matched segment free
    logic    split_lo;  // write the new used segment into the spare entry
    logic    split_hi;  // shrink the chosen free segment
    logic    res_load;  // capture the result code
    status_t res_code;
    logic    out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic is_free;
    logic req_zero;
    logic best_fnd;
    logic spare_fnd;
    logic exact;
    logic out_free;
  } stat_t;

endpackage

>>> design/ffba_if.sv
// Channel interfaces of the first-fit block allocator: request, result and configuration.
// Depends on ffba_pkg.
interface ffba_req_if #(
  parameter int OFFSET_BITS = 20
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [OFFSET_BITS:0]   request_bytes;
  logic [OFFSET_BITS-1:0] block_offset;

  modport source (output valid, output opcode, output request_bytes, output block_offset,
                  input ready);
  modport sink   (input valid, input opcode, input request_bytes, input block_offset,
                  output ready);
endinterface

interface ffba_rsp_if #(
  parameter int OFFSET_BITS = 20
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] granted_offset;
  ffba_pkg::status_t      status;

  modport source (output valid, output granted_offset, output status, input ready);
  modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

interface ffba_cfg_if #(
  parameter int OFFSET_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [OFFSET_BITS:0] heap_bytes;

  modport source (output valid, output heap_bytes, input ready);
  modport sink   (input valid, input heap_bytes, output ready);
endinterface

>>> design/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: joins the controller and the datapath.
// Depends on ffba_pkg, ffba_if, ffba_ctrl, ffba_dp (and through it ffba_ram).
//
//   Port    Direction  Transfer carries
//   in_ch   sink       opcode, request_bytes, block_offset
//   out_ch  source     granted_offset, status
//   cfg_ch  sink       heap_bytes
//
// Each request is handled on its own. A transfer on in_ch starts a scan that reads one table
// entry per cycle from the offset and size RAMs, then decides, splits a segment if needed and
// replies; the single read port of those RAMs sets the pace.
// After reset the controller writes table entry 0 in S_INIT; in_ch and cfg_ch are not ready then.
// The result sits in an output register, so a stalled out_ch does not stop the next request
// from being taken; only a second result waiting behind it holds the controller.
// A configuration transfer is taken only while no request is in progress.
module first_fit_block_allocator_top #(
  parameter int          MAX_SEGMENTS = 64,
  parameter int          OFFSET_BITS  = 20,
  parameter int unsigned HEAP_RESET   = 65536
) (
  input logic       clk,
  input logic       rst_n,
  ffba_req_if.sink  in_ch,
  ffba_rsp_if.source out_ch,
  ffba_cfg_if.sink  cfg_ch
);

  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t st;

  // The controller owns both ready signals and decides what the datapath does each cycle.
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the segment table, the scan trackers and the output register.
  ffba_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .OFFSET_BITS  (OFFSET_BITS),
    .HEAP_RESET   (HEAP_RESET)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_opcode          (in_ch.opcode),
    .in_request_bytes   (in_ch.request_bytes),
    .in_block_offset    (in_ch.block_offset),
    .cfg_heap_bytes     (cfg_ch.heap_bytes),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_granted_offset (out_ch.granted_offset),
    .out_status         (out_ch.status)
  );

endmodule

>>> design/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/ffba_ctrl.sv
// Controller of the first-fit block allocator: sequences scan, decision, table update and reply.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  ffba_pkg::stat_t st,
  output ffba_pkg::cmd_t  cmd
);

  ffba_pkg::state_t state_r;
  ffba_pkg::state_t state_nxt;

  assign in_ready  = (state_r == ffba_pkg::S_IDLE);
  assign cfg_ready = (state_r == ffba_pkg::S_IDLE) && !in_valid;

  always_comb begin
    cmd       = '0;
    cmd.res_code = ffba_pkg::ST_OK;
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ffba_pkg::S_SCAN;
        end else if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = ffba_pkg::S_DECIDE;
        end
      end
      ffba_pkg::S_DECIDE: begin
        cmd.res_load = 1'b1;
        state_nxt    = ffba_pkg::S_REPLY;
        if (st.is_free) begin
          if (st.best_fnd) begin
            cmd.clr_used = 1'b1;
            cmd.res_code = ffba_pkg::ST_OK;
          end else begin
            cmd.res_code = ffba_pkg::ST_NOT_FOUND;
          end
        end else if (st.req_zero) begin
          cmd.res_code = ffba_pkg::ST_ZERO;
        end else if (!st.best_fnd) begin
          cmd.res_code = ffba_pkg::ST_NO_SPACE;
        end else if (st.exact) begin
          cmd.set_used = 1'b1;
          cmd.res_code = ffba_pkg::ST_OK;
        end else if (!st.spare_fnd) begin
          cmd.res_code = ffba_pkg::ST_TABLE_FULL;
        end else begin
          cmd.split_lo = 1'b1;
          cmd.res_code = ffba_pkg::ST_OK;
          state_nxt    = ffba_pkg::S_SPLIT;
        end
      end
      ffba_pkg::S_SPLIT: begin
        cmd.split_hi = 1'b1;
        state_nxt    = ffba_pkg::S_REPLY;
      end
      ffba_pkg::S_REPLY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/ffba_dp.sv
// Datapath of the first-fit block allocator: segment table (RAMs plus valid and used flags),
// scan pipeline, first-fit and spare trackers, result and output registers.
// Depends on ffba_pkg and ffba_ram.
module ffba_dp #(
  parameter int          MAX_SEGMENTS = 64,
  parameter int          OFFSET_BITS  = 20,
  parameter int unsigned HEAP_RESET   = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ffba_pkg::cmd_t         cmd,
  output ffba_pkg::stat_t        st,
  input  logic                   in_opcode,
  input  logic [OFFSET_BITS:0]   in_request_bytes,
  input  logic [OFFSET_BITS-1:0] in_block_offset,
  input  logic [OFFSET_BITS:0]   cfg_heap_bytes,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_granted_offset,
  output ffba_pkg::status_t      out_status
);

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int SIZE_W = OFFSET_BITS + 1;
  localparam int NEED_W = OFFSET_BITS + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);
  localparam longint unsigned CAP      = 64'd1 << OFFSET_BITS;
  localparam longint unsigned HEAP_SAT = (HEAP_RESET > CAP) ? CAP : 64'(HEAP_RESET);
  localparam logic [SIZE_W-1:0] HEAP_INIT = SIZE_W'(HEAP_SAT);

  // Latched request.
  logic                   op_r;
  logic [SIZE_W-1:0]      req_r;
  logic [OFFSET_BITS-1:0] blk_r;
  logic [NEED_W-1:0]      need_r;
  logic [NEED_W-1:0]      need_sum;

  // Scan pipeline.
  logic             iss_on_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             chk_on_r;
  logic [IDX_W-1:0] chk_idx_r;

  // Table flags.
  logic [MAX_SEGMENTS-1:0] valid_r;
  logic [MAX_SEGMENTS-1:0] used_r;

  // Trackers.
  logic                   best_fnd_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [OFFSET_BITS-1:0] best_off_r;
  logic [SIZE_W-1:0]      best_sz_r;
  logic                   spare_fnd_r;
  logic [IDX_W-1:0]       spare_idx_r;

  // Result and output.
  ffba_pkg::status_t      res_code_r;
  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] out_off_r;
  ffba_pkg::status_t      out_status_r;

  // RAM ports.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [OFFSET_BITS-1:0] off_wdata;
  logic [SIZE_W-1:0]      sz_wdata;
  logic [OFFSET_BITS-1:0] off_rd;
  logic [SIZE_W-1:0]      sz_rd;

  logic [SIZE_W-1:0] cfg_sat;
  logic              ent_valid;
  logic              ent_used;
  logic              fit_hit;
  logic              free_hit;
  logic              spare_hit;

  ffba_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_SEGMENTS)) u_off_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (off_wdata),
    .raddr (rd_idx_r),
    .rdata (off_rd)
  );

  ffba_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_SEGMENTS)) u_sz_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sz_wdata),
    .raddr (rd_idx_r),
    .rdata (sz_rd)
  );

  // A heap above the offset range saturates to it.
  assign cfg_sat = cfg_heap_bytes[OFFSET_BITS] ? SIZE_W'(CAP) : cfg_heap_bytes;

  assign need_sum = {1'b0, in_request_bytes} + NEED_W'(ffba_pkg::ALIGN_BYTES - 1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    off_wdata = '0;
    sz_wdata  = HEAP_INIT;
    if (cmd.init_wr) begin
      ram_we = 1'b1;
    end else if (cmd.cfg_wr) begin
      ram_we   = 1'b1;
      sz_wdata = cfg_sat;
    end else if (cmd.split_lo) begin
      ram_we    = 1'b1;
      ram_waddr = spare_idx_r;
      off_wdata = best_off_r;
      sz_wdata  = need_r[SIZE_W-1:0];
    end else if (cmd.split_hi) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      off_wdata = best_off_r + need_r[OFFSET_BITS-1:0];
      sz_wdata  = best_sz_r - need_r[SIZE_W-1:0];
    end
  end

  // Entry under check, one per cycle; chk_idx_r follows the RAM read address through a register.
  assign ent_valid = valid_r[chk_idx_r];
  assign ent_used  = used_r[chk_idx_r];
  assign spare_hit = chk_on_r && !ent_valid && !spare_fnd_r;
  assign fit_hit   = chk_on_r && (op_r == ffba_pkg::OP_ALLOC) && ent_valid && !ent_used &&
                     ({1'b0, sz_rd} >= need_r) && (!best_fnd_r || (off_rd < best_off_r));
  assign free_hit  = chk_on_r && (op_r == ffba_pkg::OP_FREE) && ent_valid && ent_used &&
                     (off_rd == blk_r) && !best_fnd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      req_r  <= in_request_bytes;
      blk_r  <= in_block_offset;
      need_r <= {need_sum[NEED_W-1:ffba_pkg::ALIGN_BITS], ffba_pkg::ALIGN_BITS'(0)};
    end
    chk_idx_r <= rd_idx_r;
    if (fit_hit || free_hit) begin
      best_idx_r <= chk_idx_r;
      best_off_r <= off_rd;
      best_sz_r  <= sz_rd;
    end
    if (spare_hit) begin
      spare_idx_r <= chk_idx_r;
    end
    if (cmd.res_load) begin
      res_code_r <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_code_r;
      out_off_r    <= (res_code_r == ffba_pkg::ST_OK) ? best_off_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_on_r    <= 1'b0;
      rd_idx_r    <= '0;
      chk_on_r    <= 1'b0;
      best_fnd_r  <= 1'b0;
      spare_fnd_r <= 1'b0;
      valid_r     <= MAX_SEGMENTS'(1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chk_on_r <= iss_on_r;
      if (cmd.load) begin
        iss_on_r    <= 1'b1;
        rd_idx_r    <= '0;
        best_fnd_r  <= 1'b0;
        spare_fnd_r <= 1'b0;
      end else if (iss_on_r) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
        if (rd_idx_r == LAST_IDX) begin
          iss_on_r <= 1'b0;
        end
      end
      if (fit_hit || free_hit) begin
        best_fnd_r <= 1'b1;
      end
      if (spare_hit) begin
        spare_fnd_r <= 1'b1;
      end
      if (cmd.cfg_wr) begin
        valid_r <= MAX_SEGMENTS'(1);
        used_r  <= '0;
      end
      if (cmd.set_used) begin
        used_r[best_idx_r] <= 1'b1;
      end
      if (cmd.clr_used) begin
        used_r[best_idx_r] <= 1'b0;
      end
      if (cmd.split_lo) begin
        valid_r[spare_idx_r] <= 1'b1;
        used_r[spare_idx_r]  <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.scan_done = chk_on_r && (chk_idx_r == LAST_IDX);
  assign st.is_free   = (op_r == ffba_pkg::OP_FREE);
  assign st.req_zero  = (req_r == '0);
  assign st.best_fnd  = best_fnd_r;
  assign st.spare_fnd = spare_fnd_r;
  assign st.exact     = ({1'b0, best_sz_r} == need_r);
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_off_r;
  assign out_status         = out_status_r;

endmodule

>>> test/first_fit_block_allocator_top_test.sv
// Self-checking testbench for first_fit_block_allocator_top: a cycle-free model of the segment
// table predicts every status and granted offset, and a checker compares each result transfer.
// Depends on ffba_pkg, the channel interfaces in ffba_if and the allocator RTL.
module first_fit_block_allocator_top_test;

  localparam int          MAX_SEGMENTS = 64;
  localparam int          OFFSET_BITS  = 20;
  localparam int unsigned HEAP_RESET   = 65536;
  // Largest heap the offset width can address; larger register values saturate to this.
  localparam logic [20:0] HEAP_CAP     = 21'h100000;
  // A request scans the table one entry per cycle and then passes through the control states, so
  // after this wait following the last result the block is certainly back at rest.
  localparam int          SETTLE_CYCLES = MAX_SEGMENTS + 16;

  // One expected result: what the allocator should hand back for one request.
  typedef struct packed {
    logic [19:0]       granted_offset;
    ffba_pkg::status_t status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ffba_req_if #(.OFFSET_BITS(OFFSET_BITS)) in_ch ();
  ffba_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) out_ch ();
  ffba_cfg_if #(.OFFSET_BITS(OFFSET_BITS)) cfg_ch ();

  first_fit_block_allocator_top #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .OFFSET_BITS (OFFSET_BITS),
    .HEAP_RESET  (HEAP_RESET)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------------------------
  // Shadow copy of the segment table. It is updated at the very edge at which a request transfer
  // is taken, so the stimulus can always look at the table as the block will see it.
  // ---------------------------------------------------------------------------------------------
  logic [20:0] heap_limit;
  logic [19:0] blk_base  [MAX_SEGMENTS];
  logic [20:0] blk_len   [MAX_SEGMENTS];
  bit          blk_taken [MAX_SEGMENTS];
  bit          blk_live  [MAX_SEGMENTS];

  alloc_result_t awaited_grants[$];
  alloc_result_t oldest_grant;
  int            mismatch_count = 0;

  // Percentages of cycles in which the sender holds back and the receiver refuses a result.
  int req_gap_pct   = 33;
  int rsp_stall_pct = 55;

  // Writing the heap size throws the whole table away and leaves one free segment at offset 0.
  function automatic void table_reset(input logic [20:0] raw_size);
    heap_limit = (raw_size > HEAP_CAP) ? HEAP_CAP : raw_size;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      blk_base[i]  = '0;
      blk_len[i]   = '0;
      blk_taken[i] = 1'b0;
      blk_live[i]  = 1'b0;
    end
    blk_live[0] = 1'b1;
    blk_len[0]  = heap_limit;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic alloc_result_t first_fit_outcome(input logic        op,
                                                      input logic [20:0] bytes,
                                                      input logic [19:0] off);
    alloc_result_t res;
    logic [21:0]   need;
    logic [21:0]   next_base;
    logic [19:0]   best_base;
    int            best;
    int            spare;
    bit            hit;
    res.granted_offset = '0;
    res.status         = ffba_pkg::ST_OK;
    best      = -1;
    spare     = -1;
    best_base = '0;
    hit       = 1'b0;
    if (op == ffba_pkg::OP_FREE) begin
      // Only a live, used segment that starts exactly at the offset can be released.
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (!hit && blk_live[i] && blk_taken[i] && blk_base[i] == off) begin
          blk_taken[i]       = 1'b0;
          res.granted_offset = off;
          hit                = 1'b1;
        end
      end
      if (!hit) res.status = ffba_pkg::ST_NOT_FOUND;
      return res;
    end
    if (bytes == '0) begin
      res.status = ffba_pkg::ST_ZERO;
      return res;
    end
    need = ((22'(bytes) + 22'(ffba_pkg::ALIGN_BYTES - 1)) >> ffba_pkg::ALIGN_BITS)
           << ffba_pkg::ALIGN_BITS;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (!blk_live[i]) begin
        if (spare < 0) spare = i;
      end else if (!blk_taken[i] && 22'(blk_len[i]) >= need) begin
        if (best < 0 || blk_base[i] < best_base) begin
          best      = i;
          best_base = blk_base[i];
        end
      end
    end
    if (best < 0) begin
      res.status = ffba_pkg::ST_NO_SPACE;
      return res;
    end
    if (22'(blk_len[best]) == need) begin
      blk_taken[best] = 1'b1;
    end else begin
      // A split needs a spare entry for the used low part; without one nothing changes.
      if (spare < 0) begin
        res.status = ffba_pkg::ST_TABLE_FULL;
        return res;
      end
      blk_live[spare]  = 1'b1;
      blk_taken[spare] = 1'b1;
      blk_base[spare]  = best_base;
      blk_len[spare]   = 21'(need);
      next_base        = 22'(best_base) + need;
      blk_base[best]   = next_base[19:0];
      blk_len[best]    = blk_len[best] - 21'(need);
    end
    res.granted_offset = best_base;
    return res;
  endfunction

  // Picks a random live entry that is used (or free), or -1 when there is none.
  function automatic int pick_entry(input bit want_taken);
    int hits[$];
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (blk_live[i] && blk_taken[i] == want_taken) hits.push_back(i);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic logic [20:0] random_heap_size();
    case ($urandom_range(3))
      0: return 21'($urandom_range(64, 2048));
      1: return 21'($urandom_range(2048, 65536));
      2: return 21'($urandom);
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return HEAP_CAP;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Driving and checking. Inputs change on the falling edge; handshakes and results are looked
  // at on the rising edge, where the values seen are those from before the edge.
  // ---------------------------------------------------------------------------------------------

  // The receiver refuses results at random; a fresh decision is made every cycle.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Every result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_grants.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer, offset %h status %0d", $time,
                 out_ch.granted_offset, out_ch.status);
      end else begin
        oldest_grant = awaited_grants.pop_front();
        if (out_ch.granted_offset !== oldest_grant.granted_offset) begin
          mismatch_count++;
          $display("%0t: granted_offset expected %h actual %h", $time,
                   oldest_grant.granted_offset, out_ch.granted_offset);
        end
        if (out_ch.status !== oldest_grant.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, oldest_grant.status,
                   out_ch.status);
        end
      end
    end
  end

  // Presents one request, possibly after a random gap, and waits for its transfer. Valid is
  // left high on return so that back-to-back requests need no lowering in between.
  task automatic send_request(input logic op, input logic [20:0] bytes, input logic [19:0] off);
    @(negedge clk);
    while ($urandom_range(99) < req_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.request_bytes <= bytes;
    in_ch.block_offset  <= off;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_grants.push_back(first_fit_outcome(op, bytes, off));
  endtask

  // Drops valid, waits for every outstanding result and then lets the scan machinery settle.
  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only made with the block at rest.
  task automatic write_heap_size(input logic [20:0] size_bytes);
    wait_results_done();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.heap_bytes <= size_bytes;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    table_reset(size_bytes);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: small allocations, near and exact fits of free segments and
  // releases of live allocations, with some double frees, interior offsets and wild values.
  // Fields that the operation ignores carry random values throughout.
  task automatic send_random_item();
    int          pick;
    int          idx;
    logic        op;
    logic [20:0] bytes;
    logic [19:0] off;
    pick  = $urandom_range(99);
    op    = ffba_pkg::OP_ALLOC;
    bytes = 21'($urandom);
    off   = 20'($urandom);
    if (pick < 45) begin
      bytes = 21'($urandom_range(1, 96));
      if ($urandom_range(9) == 0) bytes = 21'($urandom_range(1, int'(heap_limit) / 4 + 1));
    end else if (pick < 55) begin
      idx = pick_entry(1'b0);
      if (idx >= 0 && blk_len[idx] > 21'(ffba_pkg::ALIGN_BYTES)) begin
        bytes = blk_len[idx] - 21'($urandom_range(0, ffba_pkg::ALIGN_BYTES - 1));
      end else if (idx >= 0 && blk_len[idx] != '0) begin
        bytes = blk_len[idx];
      end
    end else if (pick < 85) begin
      op  = ffba_pkg::OP_FREE;
      idx = pick_entry(1'b1);
      if (idx >= 0) off = blk_base[idx];
    end else if (pick < 90) begin
      // Start of a free segment (a double free) or a little way into one.
      op  = ffba_pkg::OP_FREE;
      idx = pick_entry(1'b0);
      if (idx >= 0) off = blk_base[idx] + 20'($urandom_range(0, ffba_pkg::ALIGN_BYTES));
    end else if (pick < 95) begin
      op = ffba_pkg::OP_ALLOC;
    end else if (pick < 97) begin
      bytes = '0;
    end else begin
      op = ffba_pkg::OP_FREE;
    end
    send_request(op, bytes, off);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Hand-picked requests: first on the heap size left by reset, then on an empty heap, on a
  // saturated register value and on the largest heap, where offsets reach the top bits.
  task automatic test_directed();
    send_request(ffba_pkg::OP_ALLOC, 21'd0, 20'hFFFFF);        // zero request
    send_request(ffba_pkg::OP_ALLOC, 21'd1, 20'd0);            // rounded up and split off
    send_request(ffba_pkg::OP_ALLOC, 21'd8, 20'd0);
    send_request(ffba_pkg::OP_ALLOC, 21'h1FFFFF, 20'd0);       // far too large
    send_request(ffba_pkg::OP_ALLOC, HEAP_CAP, 20'd0);
    send_request(ffba_pkg::OP_FREE, 21'h1FFFFF, 20'd0);
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'd0);             // double free
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'd12);            // inside a used segment
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'hFFFFF);         // nowhere near anything
    send_request(ffba_pkg::OP_ALLOC, 21'd5, 20'd0);            // exact fit of the freed low segment
    send_request(ffba_pkg::OP_ALLOC, 21'd65520, 20'd0);        // exact fit of the remainder
    send_request(ffba_pkg::OP_ALLOC, 21'd8, 20'd0);            // nothing free left
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'd16);
    write_heap_size(21'd0);
    send_request(ffba_pkg::OP_ALLOC, 21'd1, 20'd0);
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'd0);
    write_heap_size(21'h1FFFFF);
    send_request(ffba_pkg::OP_ALLOC, 21'd1048570, 20'd0);      // whole saturated heap in one piece
    send_request(ffba_pkg::OP_ALLOC, 21'd8, 20'd0);
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'd0);
    write_heap_size(HEAP_CAP);
    send_request(ffba_pkg::OP_ALLOC, 21'd1048568, 20'd0);
    send_request(ffba_pkg::OP_ALLOC, 21'd8, 20'd0);            // lands at the very top of the heap
    send_request(ffba_pkg::OP_FREE, 21'd0, 20'hFFFF8);
  endtask

  // Fills every spare table entry with small allocations so that the next split is refused, then
  // keeps going with mixed traffic on the crowded table.
  task automatic test_table_full();
    write_heap_size(21'(HEAP_RESET));
    repeat (MAX_SEGMENTS - 1) send_request(ffba_pkg::OP_ALLOC, 21'($urandom_range(1, 64)),
                                           20'($urandom));
    send_request(ffba_pkg::OP_ALLOC, 21'd1000, 20'($urandom));
    repeat (40) send_random_item();
  endtask

  // Random traffic in several heap settings, moving through the three idling patterns.
  task automatic test_random_traffic();
    for (int round = 0; round < 8; round++) begin
      if (round == 3) begin
        req_gap_pct   = 55;
        rsp_stall_pct = 33;
      end else if (round == 6) begin
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
      end
      write_heap_size(random_heap_size());
      repeat (70) send_random_item();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = ffba_pkg::OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_offset  = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.heap_bytes   = '0;
    out_ch.ready        = 1'b0;
    table_reset(21'(HEAP_RESET));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_random_traffic();
    wait_results_done();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Backstop against a hung handshake: several times the slowest plausible run.
  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
